[sv/hadamard_gf256_inverse_unit_assert.svh]
// Assertion macros for the Hadamard GF(2^8) inverse unit.
`ifndef HADAMARD_GF256_INVERSE_UNIT_ASSERT_SVH
`define HADAMARD_GF256_INVERSE_UNIT_ASSERT_SVH

// Plain property check, clocked on clk, off during reset.
`define HGI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication check.
`define HGI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[sv/hgi_pkg.sv]
// Package: field arithmetic, matrix types and codes of the inverse unit.
package hgi_pkg;

	typedef logic [3:0][7:0] row_t;
	typedef logic [3:0][3:0][7:0] mat_t;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_SINGULAR     = 2'd1,
		ST_ZERO_ENTRY   = 2'd2,
		ST_NOT_HADAMARD = 2'd3
	} status_t;

	// pipeline control handed to each section
	typedef struct packed {
		logic adv;
		logic valid;
	} pipe_ctl_t;

	localparam logic [8:0] FIELD_POLY_RESET = 9'd357;
	localparam logic       REG_FIELD_POLY   = 1'b0;

	// carry-less product reduced by x^8 + low
	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] low);
		logic [14:0] p;
		logic [14:0] md;
		p  = '0;
		md = {6'd0, 1'b1, low};
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				p = p ^ ({7'd0, a} << i);
		end
		for (int i = 14; i >= 8; i--) begin
			if (p[i])
				p = p ^ (md << (i - 8));
		end
		return p[7:0];
	endfunction

	// row/column index after removing one line
	function automatic logic [1:0] skip_idx(input logic [1:0] k, input logic [1:0] skip);
		return (k >= skip) ? k + 2'd1 : k;
	endfunction

endpackage

[sv/hadamard_gf256_inverse_unit.sv]
// Top level: inverse of a 4x4 Hadamard matrix over GF(2^8), fully pipelined.
// Pipeline: 4 minor/det stages, 8 power-chain stages, scale stage,
//   status/output register.
// Throughput: one item per cycle; the whole pipe advances unless the output
//   register holds an untaken result. The 7-step det^254 chain sets the depth.
// Reset: arst_n clears all valid bits and restores field_poly to 357.
module hadamard_gf256_inverse_unit import hgi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// APB-style config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [0:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// item channel
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [7:0]  elem0,
	input  logic [7:0]  elem1,
	input  logic [7:0]  elem2,
	input  logic [7:0]  elem3,
	// result channel
	output logic        res_valid,
	input  logic        res_ready,
	output logic [1:0]  status,
	output logic [7:0]  determinant,
	output logic [7:0]  inv0,
	output logic [7:0]  inv1,
	output logic [7:0]  inv2,
	output logic [7:0]  inv3
);

	logic [8:0] field_poly_q;
	logic       adv;
	pipe_ctl_t  ctl_in, ctl_mid;
	logic       m_valid, p_valid;
	mat_t       m_minors, p_minors;
	logic [7:0] m_det, p_det, p_scale;

	// scale stage
	logic       v_s13;
	mat_t       adj_s13;
	logic [7:0] det_s13;
	// output stage
	logic       v_s14;
	status_t    status_s14;
	logic [7:0] det_s14;
	row_t       inv_s14;
	status_t    status_c;
	mat_t       inv_c;

	// ---- config register ----
	assign pready = 1'b1;
	assign prdata = (paddr == REG_FIELD_POLY) ? {23'd0, field_poly_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			field_poly_q <= FIELD_POLY_RESET;
		else if (psel && penable && pwrite && pready && paddr == REG_FIELD_POLY)
			field_poly_q <= pwdata[8:0];
	end

	// ---- global advance: stall only when the output holds an untaken result ----
	assign adv        = !v_s14 || res_ready;
	assign item_ready = adv;

	assign ctl_in  = '{adv: adv, valid: item_valid};
	assign ctl_mid = '{adv: adv, valid: m_valid};

	hgi_minor u_minor (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl_in),
		.elem     ({elem3, elem2, elem1, elem0}),
		.poly_low (field_poly_q[7:0]),
		.valid    (m_valid),
		.minors   (m_minors),
		.det      (m_det)
	);

	hgi_inv u_inv (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl_mid),
		.minors_in (m_minors),
		.det_in    (m_det),
		.poly_low  (field_poly_q[7:0]),
		.valid     (p_valid),
		.minors    (p_minors),
		.det       (p_det),
		.scale     (p_scale)
	);

	// ---- adjugate scaling: adj[i][j] = det^254 * minor(i,j) ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
		end else if (adv) begin
			v_s13 <= p_valid;
			v_s14 <= v_s13;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			det_s13 <= p_det;
			for (int i = 0; i < 4; i++)
				for (int j = 0; j < 4; j++)
					adj_s13[i][j] <= gf_mul(p_scale, p_minors[i][j], field_poly_q[7:0]);
		end
	end

	// ---- status: inverse is the transposed adjugate ----
	always_comb begin
		logic any_zero, not_had;
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++)
				inv_c[i][j] = adj_s13[j][i];
		any_zero = 1'b0;
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++)
				if (inv_c[i][j] == 8'd0)
					any_zero = 1'b1;
		not_had = (inv_c[1][0] != inv_c[0][1]) || (inv_c[1][1] != inv_c[0][0]) ||
			(inv_c[1][2] != inv_c[0][3]) || (inv_c[1][3] != inv_c[0][2]);
		for (int j = 0; j < 4; j++)
			if (inv_c[0][j] != inv_c[3][3-j] || inv_c[1][j] != inv_c[2][3-j])
				not_had = 1'b1;
		priority if (det_s13 == 8'd0)
			status_c = ST_SINGULAR;
		else if (any_zero)
			status_c = ST_ZERO_ENTRY;
		else if (not_had)
			status_c = ST_NOT_HADAMARD;
		else
			status_c = ST_OK;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s14 <= status_c;
			det_s14    <= det_s13;
			// singular: scale is zero, so the row is already zero
			inv_s14    <= inv_c[0];
		end
	end

	assign res_valid   = v_s14;
	assign status      = status_s14;
	assign determinant = det_s14;
	assign inv0        = inv_s14[0];
	assign inv1        = inv_s14[1];
	assign inv2        = inv_s14[2];
	assign inv3        = inv_s14[3];

	`include "hadamard_gf256_inverse_unit_assert.svh"

	`HGI_ASSERT_IMP(a_sing_det, res_valid, ((determinant == 8'd0) == (status == ST_SINGULAR)), "singular status and zero determinant disagree")
	`HGI_ASSERT_IMP(a_sing_zero, res_valid && status == ST_SINGULAR, (inv0 == 8'd0 && inv1 == 8'd0 && inv2 == 8'd0 && inv3 == 8'd0), "singular result with nonzero inverse")
	`HGI_ASSERT(a_stall_in, (!(res_valid && !res_ready) || !item_ready), "item taken while output stalled")

endmodule

[sv/hgi_minor.sv]
// All sixteen 3x3 minors and the determinant, four register stages.
module hgi_minor import hgi_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  pipe_ctl_t  ctl,
	input  row_t       elem,
	input  logic [7:0] poly_low,
	output logic       valid,
	output mat_t       minors,
	output logic [7:0] det
);

	logic v_s1, v_s2, v_s3, v_s4;
	row_t e_s1, e_s2, e_s3;
	mat_t pp_s2, minor_s3, minor_s4;
	logic [7:0] det_s4;
	mat_t pp_c, minor_c;
	logic [7:0] det_c;

	// pairwise products e[a]*e[b]
	always_comb begin
		for (int a = 0; a < 4; a++)
			for (int b = 0; b < 4; b++)
				pp_c[a][b] = gf_mul(e_s1[a], e_s1[b], poly_low);
	end

	// entry m[r][c] is e[r^c]
	always_comb begin
		logic [1:0] r0, r1, r2, c0, c1, c2;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				r0 = skip_idx(2'd0, 2'(r));
				r1 = skip_idx(2'd1, 2'(r));
				r2 = skip_idx(2'd2, 2'(r));
				c0 = skip_idx(2'd0, 2'(c));
				c1 = skip_idx(2'd1, 2'(c));
				c2 = skip_idx(2'd2, 2'(c));
				minor_c[r][c] =
					gf_mul(e_s2[r0 ^ c0], pp_s2[r1 ^ c1][r2 ^ c2] ^ pp_s2[r1 ^ c2][r2 ^ c1],
						poly_low) ^
					gf_mul(e_s2[r0 ^ c1], pp_s2[r1 ^ c0][r2 ^ c2] ^ pp_s2[r1 ^ c2][r2 ^ c0],
						poly_low) ^
					gf_mul(e_s2[r0 ^ c2], pp_s2[r1 ^ c0][r2 ^ c1] ^ pp_s2[r1 ^ c1][r2 ^ c0],
						poly_low);
			end
		end
	end

	// expansion along the first row
	always_comb begin
		det_c = '0;
		for (int j = 0; j < 4; j++)
			det_c = det_c ^ gf_mul(e_s3[j], minor_s3[0][j], poly_low);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (ctl.adv) begin
			v_s1 <= ctl.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			e_s1     <= elem;
			e_s2     <= e_s1;
			pp_s2    <= pp_c;
			e_s3     <= e_s2;
			minor_s3 <= minor_c;
			minor_s4 <= minor_s3;
			det_s4   <= det_c;
		end
	end

	assign valid  = v_s4;
	assign minors = minor_s4;
	assign det    = det_s4;

endmodule

[sv/hgi_inv.sv]
// det^254 by a squaring chain: one square and one product per stage.
module hgi_inv import hgi_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  pipe_ctl_t  ctl,
	input  mat_t       minors_in,
	input  logic [7:0] det_in,
	input  logic [7:0] poly_low,
	output logic       valid,
	output mat_t       minors,
	output logic [7:0] det,
	output logic [7:0] scale
);

	localparam int Steps = 7;

	// index 0 holds det^2 and sc = 1; each later index one step further
	logic       v_sc [Steps+1];
	logic [7:0] pw_sc [Steps];
	logic [7:0] sc_sc [Steps+1];
	logic [7:0] det_sc [Steps+1];
	mat_t       minor_sc [Steps+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= Steps; k++)
				v_sc[k] <= 1'b0;
		end else if (ctl.adv) begin
			v_sc[0] <= ctl.valid;
			for (int k = 1; k <= Steps; k++)
				v_sc[k] <= v_sc[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			pw_sc[0]    <= gf_mul(det_in, det_in, poly_low);
			sc_sc[0]    <= 8'd1;
			det_sc[0]   <= det_in;
			minor_sc[0] <= minors_in;
			for (int k = 1; k <= Steps; k++) begin
				sc_sc[k]    <= gf_mul(sc_sc[k-1], pw_sc[k-1], poly_low);
				det_sc[k]   <= det_sc[k-1];
				minor_sc[k] <= minor_sc[k-1];
			end
			// the last square is never needed
			for (int k = 1; k < Steps; k++)
				pw_sc[k] <= gf_mul(pw_sc[k-1], pw_sc[k-1], poly_low);
		end
	end

	assign valid  = v_sc[Steps];
	assign minors = minor_sc[Steps];
	assign det    = det_sc[Steps];
	assign scale  = sc_sc[Steps];

endmodule

[dv/tb.sv]
// Self-checking testbench for the Hadamard GF(2^8) inverse unit.
module tb;
	import hgi_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 30;

	// one expected result
	typedef struct {
		status_t    st;
		logic [7:0] det;
		row_t       inv;
	} inv_result_t;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [0:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        item_valid, item_ready;
	logic [7:0]  elem0, elem1, elem2, elem3;
	logic        res_valid, res_ready;
	logic [1:0]  status;
	logic [7:0]  determinant, inv0, inv1, inv2, inv3;

	hadamard_gf256_inverse_unit dut (.*);

	// predictor copy of the field polynomial register
	logic [8:0]  poly_shadow;
	inv_result_t inverse_q[$];
	int          err_cnt;
	int          rows_sent;
	int          results_seen;
	int          singular_seen, zero_entry_seen, not_had_seen, ok_seen;
	int          idle_pct;
	int          stall_pct;
	int          hold_left;
	int          quiet_cycles;

	// 2 ns clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// ---------------------------------------------------------------
	// Predictor: field product, minors, determinant and inverse row
	// ---------------------------------------------------------------
	function automatic logic [7:0] field_mult(input logic [7:0] a, input logic [7:0] b);
		logic [14:0] acc;
		logic [14:0] red;
		acc = '0;
		// bit 8 of the polynomial is forced to one
		red = {6'd0, 1'b1, poly_shadow[7:0]};
		for (int i = 0; i < 8; i++)
			if (b[i])
				acc ^= {7'd0, a} << i;
		for (int i = 14; i >= 8; i--)
			if (acc[i])
				acc ^= red << (i - 8);
		return acc[7:0];
	endfunction

	// 3x3 determinant of the matrix with one row and one column struck out;
	// no signs are needed in characteristic 2
	function automatic logic [7:0] cofactor_of(input logic [7:0] m[4][4], input int sr,
			input int sc);
		logic [7:0] s[3][3];
		logic [7:0] d;
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				s[r][c] = m[(r >= sr) ? r + 1 : r][(c >= sc) ? c + 1 : c];
		d = field_mult(s[0][0], field_mult(s[1][1], s[2][2]) ^ field_mult(s[1][2], s[2][1]));
		d ^= field_mult(s[0][1], field_mult(s[1][0], s[2][2]) ^ field_mult(s[1][2], s[2][0]));
		d ^= field_mult(s[0][2], field_mult(s[1][0], s[2][1]) ^ field_mult(s[1][1], s[2][0]));
		return d;
	endfunction

	function automatic inv_result_t predict_inverse(input row_t e);
		logic [7:0]  m[4][4];
		logic [7:0]  iv[4][4];
		logic [7:0]  scale, sq;
		inv_result_t r;
		for (int j = 0; j < 4; j++)
			for (int i = 0; i < 4; i++)
				m[i][j] = e[j ^ i];
		r.det = '0;
		for (int j = 0; j < 4; j++)
			r.det ^= field_mult(m[0][j], cofactor_of(m, 0, j));
		r.inv = '0;
		if (r.det == 8'd0) begin
			r.st = ST_SINGULAR;
			return r;
		end
		// det^254 by seven squarings
		scale = 8'd1;
		sq    = r.det;
		for (int k = 0; k < 7; k++) begin
			sq    = field_mult(sq, sq);
			scale = field_mult(scale, sq);
		end
		// adjugate is the transposed cofactor matrix
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++)
				iv[j][i] = field_mult(scale, cofactor_of(m, i, j));
		r.st = ST_OK;
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++)
				if (iv[i][j] == 8'd0)
					r.st = ST_ZERO_ENTRY;
		// zero-entry wins over the Hadamard-form check
		if (r.st == ST_OK) begin
			if (iv[1][0] != iv[0][1] || iv[1][1] != iv[0][0] ||
					iv[1][2] != iv[0][3] || iv[1][3] != iv[0][2])
				r.st = ST_NOT_HADAMARD;
			for (int j = 0; j < 4; j++)
				if (iv[0][j] != iv[3][3 - j] || iv[1][j] != iv[2][3 - j])
					r.st = ST_NOT_HADAMARD;
		end
		for (int j = 0; j < 4; j++)
			r.inv[j] = iv[0][j];
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Result side: ready pattern and checking, sampled at rising edge
	// ---------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else if (hold_left > 0) begin
			// long hold-off so the pipe fills and stalls the item input
			res_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			res_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		inv_result_t want;
		if (arst_n && res_valid && res_ready) begin
			results_seen++;
			if (inverse_q.size() == 0) begin
				$error("result with no item outstanding: status %0d det %0h", status,
					determinant);
				err_cnt++;
			end else begin
				want = inverse_q.pop_front();
				if (status != want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					err_cnt++;
				end
				if (determinant != want.det) begin
					$error("determinant: expected %0h, got %0h", want.det, determinant);
					err_cnt++;
				end
				if (inv0 != want.inv[0]) begin
					$error("inv0: expected %0h, got %0h", want.inv[0], inv0);
					err_cnt++;
				end
				if (inv1 != want.inv[1]) begin
					$error("inv1: expected %0h, got %0h", want.inv[1], inv1);
					err_cnt++;
				end
				if (inv2 != want.inv[2]) begin
					$error("inv2: expected %0h, got %0h", want.inv[2], inv2);
					err_cnt++;
				end
				if (inv3 != want.inv[3]) begin
					$error("inv3: expected %0h, got %0h", want.inv[3], inv3);
					err_cnt++;
				end
				case (want.st)
					ST_OK:           ok_seen++;
					ST_SINGULAR:     singular_seen++;
					ST_ZERO_ENTRY:   zero_entry_seen++;
					default:         not_had_seen++;
				endcase
			end
		end
	end

	// watchdog: cycles with no item and no result moving
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (res_valid && res_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
			$display("** hadamard_gf256_inverse_unit: FAILED **");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	// send one row; valid is left high so back-to-back items never drop it
	task automatic send_row(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
			input logic [7:0] d);
		@(negedge clk);
		if ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < idle_pct)
				@(negedge clk);
		end
		item_valid <= 1'b1;
		elem0      <= a;
		elem1      <= b;
		elem2      <= c;
		elem3      <= d;
		inverse_q.push_back(predict_inverse({d, c, b, a}));
		rows_sent++;
		do
			@(posedge clk);
		while (!item_ready);
	endtask

	task automatic end_items();
		@(negedge clk);
		item_valid <= 1'b0;
	endtask

	// wait for every result, then let the pipe settle
	task automatic drain();
		end_items();
		while (inverse_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_poly(input logic [31:0] v);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_FIELD_POLY;
		pwdata  <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		pwdata  <= '0;
		poly_shadow = v[8:0];
		// read back through the same port
		@(negedge clk);
		psel    <= 1'b1;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[8:0] != poly_shadow) begin
			$error("field_poly readback: expected %0h, got %0h", poly_shadow, prdata[8:0]);
			err_cnt++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// random row: mostly free, some forced singular (xor of the row is zero
	// exactly when det = (e0^e1^e2^e3)^4 vanishes), some with zeros
	task automatic send_random_row();
		logic [7:0] a, b, c, d;
		int         pick;
		a    = 8'($urandom);
		b    = 8'($urandom);
		c    = 8'($urandom);
		d    = 8'($urandom);
		pick = $urandom_range(99);
		if (pick < 12)
			d = a ^ b ^ c;
		else if (pick < 20)
			case ($urandom_range(3))
				0: a = '0;
				1: b = '0;
				2: c = '0;
				default: d = '0;
			endcase
		else if (pick < 25)
			{b, c, d} = {$urandom_range(1) ? 8'hff : 8'h00, 8'h00, 8'h00};
		send_row(a, b, c, d);
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	task automatic test_directed();
		idle_pct  = 0;
		stall_pct = 0;
		send_row(8'h00, 8'h00, 8'h00, 8'h00);   // all zero: singular
		send_row(8'hff, 8'hff, 8'hff, 8'hff);   // equal entries: singular
		send_row(8'h01, 8'h00, 8'h00, 8'h00);   // identity
		send_row(8'h00, 8'h01, 8'h00, 8'h00);
		send_row(8'h00, 8'h00, 8'h01, 8'h00);
		send_row(8'h00, 8'h00, 8'h00, 8'h01);
		send_row(8'hff, 8'h00, 8'h00, 8'h00);   // scaled identity, max element
		send_row(8'h80, 8'h00, 8'h00, 8'h00);
		send_row(8'h01, 8'h01, 8'h00, 8'h00);   // singular pair
		send_row(8'h02, 8'h03, 8'h01, 8'h01);   // MDS-like row
		send_row(8'h01, 8'h02, 8'h04, 8'h08);
		send_row(8'hff, 8'hfe, 8'h80, 8'h7f);
		send_row(8'h55, 8'haa, 8'h0f, 8'hf0);
		send_row(8'h12, 8'h34, 8'h56, 8'h78);
		drain();
		// reducible x^8 and a polynomial written without its top bit
		write_poly(32'h100);
		send_row(8'h02, 8'h03, 8'h01, 8'h01);
		send_row(8'h80, 8'h40, 8'h20, 8'h11);
		send_row(8'hff, 8'h01, 8'h00, 8'h00);
		drain();
		write_poly(32'h01b);
		send_row(8'h02, 8'h03, 8'h01, 8'h01);
		send_row(8'hff, 8'h00, 8'h00, 8'h00);
		send_row(8'h80, 8'h80, 8'h01, 8'h00);
		drain();
	endtask

	task automatic test_random_phase(input logic [31:0] poly, input int n_rows,
			input int ipct, input int spct);
		write_poly(poly);
		idle_pct  = ipct;
		stall_pct = spct;
		for (int k = 0; k < n_rows; k++) begin
			// stretches with no idling inside every phase
			if (k % 100 == 50) begin
				idle_pct  = 0;
				stall_pct = 0;
			end else if (k % 100 == 70) begin
				idle_pct  = ipct;
				stall_pct = spct;
			end
			send_random_row();
		end
		drain();
	endtask

	task automatic test_backpressure();
		write_poly(32'h1ff);
		idle_pct  = 0;
		stall_pct = 0;
		hold_left = 400;
		for (int k = 0; k < 80; k++)
			send_random_row();
		drain();
	endtask

	initial begin
		arst_n     = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		item_valid = 1'b0;
		elem0      = '0;
		elem1      = '0;
		elem2      = '0;
		elem3      = '0;
		res_ready  = 1'b0;
		poly_shadow     = FIELD_POLY_RESET;
		err_cnt         = 0;
		rows_sent       = 0;
		results_seen    = 0;
		singular_seen   = 0;
		zero_entry_seen = 0;
		not_had_seen    = 0;
		ok_seen         = 0;
		idle_pct        = 0;
		stall_pct       = 0;
		hold_left       = 0;
		quiet_cycles    = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_phase(32'h165, 400, 0, 0);
		test_random_phase(32'h11b, 380, 87, 0);
		test_random_phase(32'h000, 380, 0, 87);
		test_random_phase(32'h1ff, 380, 25, 25);
		test_backpressure();
		write_poly(32'h165);

		$display("%0d rows under six field_poly settings, %0d results checked", rows_sent,
			results_seen);
		$display("status mix: ok %0d, singular %0d, zero entry %0d, not Hadamard %0d",
			ok_seen, singular_seen, zero_entry_seen, not_had_seen);
		if (err_cnt == 0)
			$display("** hadamard_gf256_inverse_unit: PASSED **");
		else
			$display("** hadamard_gf256_inverse_unit: FAILED **");
		$finish;
	end

endmodule

[filelist.f]
+incdir+sv
sv/hgi_pkg.sv
sv/hgi_minor.sv
sv/hgi_inv.sv
sv/hadamard_gf256_inverse_unit.sv
dv/tb.sv
